// ===== rtl/core/ncs_pkg.sv =====
// shared types, constants and helpers for the nearest palette colour search
`default_nettype none
package ncs_pkg;

  localparam int PAL_ENTRIES = 256;
  localparam int PAL_AW      = $clog2(PAL_ENTRIES);
  localparam int CNT_W       = PAL_AW + 1;
  localparam int DIST_W      = 20;
  localparam int FB_FIRST    = PAL_ENTRIES - 2;
  localparam int FB_LAST     = 49;

  localparam logic [7:0] COMP_MASK = 8'hFC;
  localparam logic [7:0] WHITE_MIN = 8'd252;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_REMAP = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EVAL,
    ST_FALLBACK,
    ST_DONE
  } st_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] idx;
    logic [9:0] r;
    logic [9:0] g;
    logic [9:0] b;
    logic       lim_en;
    logic [7:0] lim_lvl;
  } item_t;

  typedef struct packed {
    logic              we;
    logic [PAL_AW-1:0] waddr;
    logic [23:0]       wdata;
    logic              re;
    logic [PAL_AW-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] idx;
    logic       exact;
    logic       claimed;
  } res_t;

  function automatic logic [7:0] sat_mask(input logic [9:0] v);
    logic [7:0] c;
    c = (|v[9:8]) ? 8'hFF : v[7:0];
    return c & COMP_MASK;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/nearest_palette_color_search.sv =====
// top level of the nearest palette colour search with its result register
`default_nettype none
// Holds a palette of ncs_pkg::PAL_ENTRIES 24-bit RGB entries, black after reset.
// A write item stores a colour in the addressed entry. A remap item
// reads the palette one entry per cycle through the single read port of the
// palette memory and stops early when an exact match turns up; when the best
// distance is over the enabled limit, a near-white fallback scan reads down
// from entry PAL_ENTRIES - 2 to entry 49. One item is in work at a time; the
// next item is taken while the previous result waits in the output register.
module nearest_palette_color_search (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  logic       opcode,
  input  logic [7:0] entry_index,
  input  logic [9:0] red,
  input  logic [9:0] green,
  input  logic [9:0] blue,
  input  logic       limit_enable,
  input  logic [7:0] limit_level,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  output logic [7:0] chosen_index,
  output logic       exact_hit,
  output logic       entry_claimed
);
  import ncs_pkg::*;

  item_t       item;
  ram_req_t    ram;
  res_t        res;
  logic [23:0] rdata;
  logic        busy;
  logic        res_take;

  assign item.op      = op_t'(opcode);
  assign item.idx     = entry_index;
  assign item.r       = red;
  assign item.g       = green;
  assign item.b       = blue;
  assign item.lim_en  = limit_enable;
  assign item.lim_lvl = limit_level;

  assign req_stall = busy;
  assign res_take  = !rsp_valid || !rsp_stall;

  ncs_search u_search (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .item      (item),
    .busy      (busy),
    .rdata     (rdata),
    .ram       (ram),
    .res       (res),
    .res_take  (res_take)
  );

  ncs_palette u_palette (
    .clk   (clk),
    .rst   (rst),
    .req   (ram),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_take) begin
      rsp_valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && res.valid) begin
      chosen_index  <= res.idx;
      exact_hit     <= res.exact;
      entry_claimed <= res.claimed;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/ncs_palette.sv =====
// palette memory with per-entry valid bits, one write and one registered read port
`default_nettype none
module ncs_palette (
  input  logic              clk,
  input  logic              rst,
  input  ncs_pkg::ram_req_t req,
  output logic [23:0]       rdata
);
  import ncs_pkg::*;

  logic [23:0]            mem [PAL_ENTRIES];
  logic [PAL_ENTRIES-1:0] vld;
  logic [23:0]            rd_q;
  logic                   vld_q;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_q <= mem[req.raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      vld_q <= 1'b0;
    end else begin
      if (req.we) begin
        vld[req.waddr] <= 1'b1;
      end
      if (req.re) begin
        vld_q <= vld[req.raddr];
      end
    end
  end

  // never-written entries read as black
  assign rdata = vld_q ? rd_q : 24'd0;

endmodule
`default_nettype wire

// ===== rtl/core/ncs_search.sv =====
// sequencer and distance datapath for palette scan, limit check and fallback claim
`default_nettype none
module ncs_search (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  ncs_pkg::item_t    item,
  output logic              busy,
  input  logic [23:0]       rdata,
  output ncs_pkg::ram_req_t ram,
  output ncs_pkg::res_t     res,
  input  logic              res_take
);
  import ncs_pkg::*;

  st_t               state, state_next;
  logic [CNT_W-1:0]  rd_cnt;
  logic [7:0]        tgt_r, tgt_g, tgt_b;
  logic              lim_en;
  logic [7:0]        lim_lvl;
  logic [15:0]       lim_sq;
  logic [DIST_W-1:0] lim_w;
  logic              s1_vld;
  logic [PAL_AW-1:0] s1_idx;
  logic              s2_vld;
  logic [PAL_AW-1:0] s2_idx;
  logic              s2_exact;
  logic [15:0]       sq_r, sq_g, sq_b;
  logic [DIST_W-1:0] best_sum;
  logic [PAL_AW-1:0] best_idx;
  logic [7:0]        res_idx;
  logic              res_exact, res_claimed;

  logic              accept;
  logic              issue_scan, issue_fb;
  logic [7:0]        ar, ag, ab;
  logic [7:0]        dr, dg, db;
  logic              s1_exact;
  logic [DIST_W-1:0] wsum;
  logic              better;
  logic              exact_done, scan_end;
  logic              white_hit, fb_end;
  logic              over;

  assign accept     = req_valid && (state == ST_IDLE);
  assign issue_scan = (state == ST_SCAN) && (rd_cnt < CNT_W'(PAL_ENTRIES));
  assign issue_fb   = (state == ST_FALLBACK) && (rd_cnt >= CNT_W'(FB_LAST));

  assign ar = rdata[23:16] & COMP_MASK;
  assign ag = rdata[15:8]  & COMP_MASK;
  assign ab = rdata[7:0]   & COMP_MASK;
  assign dr = (ar > tgt_r) ? (ar - tgt_r) : (tgt_r - ar);
  assign dg = (ag > tgt_g) ? (ag - tgt_g) : (tgt_g - ag);
  assign db = (ab > tgt_b) ? (ab - tgt_b) : (tgt_b - ab);
  assign s1_exact = (ar == tgt_r) && (ag == tgt_g) && (ab == tgt_b);

  assign wsum = (DIST_W'(sq_r) << 1) + DIST_W'(sq_r)
              + (DIST_W'(sq_g) << 2) + (DIST_W'(sq_g) << 1)
              + (DIST_W'(sq_b) << 1);

  assign exact_done = (state == ST_SCAN) && s2_vld && s2_exact;
  assign scan_end   = (state == ST_SCAN) && s2_vld && !s2_exact
                   && (s2_idx == PAL_AW'(PAL_ENTRIES - 1));
  assign better     = (state == ST_SCAN) && s2_vld && !s2_exact && (wsum < best_sum);
  assign white_hit  = (state == ST_FALLBACK) && s1_vld
                   && (rdata[23:16] >= WHITE_MIN) && (rdata[15:8] >= WHITE_MIN)
                   && (rdata[7:0] >= WHITE_MIN);
  assign fb_end     = (state == ST_FALLBACK) && s1_vld && !white_hit
                   && (s1_idx == PAL_AW'(FB_LAST));
  assign over       = lim_en && (best_sum > lim_w);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (item.op == OP_WRITE) ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (exact_done) begin
          state_next = ST_DONE;
        end else if (scan_end) begin
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_next = over ? ST_FALLBACK : ST_DONE;
      end
      ST_FALLBACK: begin
        if (white_hit || fb_end) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_take) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy      = (state != ST_IDLE);
    ram.we    = (accept && (item.op == OP_WRITE)
                 && ({1'b0, item.idx} < 9'(PAL_ENTRIES))) || white_hit;
    ram.waddr = white_hit ? s1_idx : item.idx[PAL_AW-1:0];
    ram.wdata = white_hit ? {tgt_r, tgt_g, tgt_b}
                          : {item.r[7:0], item.g[7:0], item.b[7:0]};
    ram.re    = issue_scan || issue_fb;
    ram.raddr = rd_cnt[PAL_AW-1:0];
    res.valid   = (state == ST_DONE);
    res.idx     = res_idx;
    res.exact   = res_exact;
    res.claimed = res_claimed;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
    end else begin
      state  <= state_next;
      s1_vld <= ram.re;
      s2_vld <= s1_vld && (state == ST_SCAN) && !exact_done;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx   <= ram.raddr;
    s2_idx   <= s1_idx;
    s2_exact <= s1_exact;
    sq_r     <= dr * dr;
    sq_g     <= dg * dg;
    sq_b     <= db * db;
    lim_sq   <= lim_lvl * lim_lvl;
    lim_w    <= (DIST_W'(lim_sq) << 3) + (DIST_W'(lim_sq) << 1) + DIST_W'(lim_sq);

    if (accept) begin
      tgt_r    <= sat_mask(item.r);
      tgt_g    <= sat_mask(item.g);
      tgt_b    <= sat_mask(item.b);
      lim_en   <= item.lim_en;
      lim_lvl  <= item.lim_lvl;
      rd_cnt   <= '0;
      best_sum <= '1;
      best_idx <= '0;
    end else if (issue_scan) begin
      rd_cnt <= rd_cnt + CNT_W'(1);
    end else if (state == ST_EVAL) begin
      rd_cnt <= CNT_W'(FB_FIRST);
    end else if (issue_fb) begin
      rd_cnt <= rd_cnt - CNT_W'(1);
    end

    if (better) begin
      best_sum <= wsum;
      best_idx <= s2_idx;
    end

    priority if (accept) begin
      res_idx     <= item.idx;
      res_exact   <= 1'b0;
      res_claimed <= 1'b0;
    end else if (exact_done) begin
      res_idx     <= 8'(s2_idx);
      res_exact   <= 1'b1;
      res_claimed <= 1'b0;
    end else if (white_hit) begin
      res_idx     <= 8'(s1_idx);
      res_exact   <= 1'b0;
      res_claimed <= 1'b1;
    end else if (((state == ST_EVAL) && !over) || fb_end) begin
      res_idx     <= 8'(best_idx);
      res_exact   <= 1'b0;
      res_claimed <= 1'b0;
    end else begin
    end
  end

  a_write_state: assert property (@(posedge clk) disable iff (rst)
    ram.we |-> (state == ST_IDLE || state == ST_FALLBACK))
    else $error("palette written outside an accept or a claim");

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> !(res.exact && res.claimed))
    else $error("exact hit and claim flagged together");

  a_claim_done: assert property (@(posedge clk) disable iff (rst)
    white_hit |=> (state == ST_DONE))
    else $error("claim did not finish the item");

  a_eval_drained: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EVAL) |-> (!s1_vld && !s2_vld))
    else $error("scan pipeline not empty at limit check");

endmodule
`default_nettype wire
